/* rtl/core/arls_pkg.sv */
// Shared constants, command/status types and controller states of the level smoother.
// No dependencies; the RTL files refer to it by scoped names and the bench files import it.
package arls_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int UNITY_GAIN   = 256;

    localparam int CHANNEL_W = 5;
    localparam int LEVEL_W   = 16;
    localparam int TIME_W    = 64;
    localparam int ELAPSED_W = 10;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Stored levels reachable through a CHANNEL_W-bit channel number.
    localparam int LEVEL_DEPTH = (NUM_CHANNELS > (2 ** CHANNEL_W)) ? (2 ** CHANNEL_W)
                                                                   : NUM_CHANNELS;
    localparam int LEVEL_IDX_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX        = '1;
    localparam logic [ELAPSED_W-1:0] FIRST_ELAPSED_MS = 10'd33;
    localparam logic [ELAPSED_W-1:0] MAX_ELAPSED_MS   = 10'd1000;
    localparam int                   US_PER_MS        = 1000;

    // Deltas at or above DELTA_CAP saturate; below it they fit DELTA_W bits.
    localparam int DELTA_CAP = (int'(MAX_ELAPSED_MS) + 1) * US_PER_MS;
    localparam int DELTA_W   = $clog2(DELTA_CAP);

    // floor(x / 1000) == (x * MS_RECIP) >> MS_RECIP_SHIFT for x < DELTA_CAP
    localparam int MS_RECIP_SHIFT = 30;
    localparam int MS_RECIP       = ((2 ** MS_RECIP_SHIFT) + US_PER_MS - 1) / US_PER_MS;
    localparam int MS_RECIP_W     = $clog2(MS_RECIP + 1);
    localparam int MS_PROD_W      = DELTA_W + MS_RECIP_W;

    // Q8 fraction divider: quotient LEVEL_W bits, numerator < denominator * 2**DIV_Q_W.
    localparam int DIV_Q_W = LEVEL_W;
    localparam int DIV_D_W = LEVEL_W + 1;
    localparam int DIV_N_W = DIV_Q_W + DIV_D_W;

    // UNITY_GAIN is a power of two; the gain divide is a shift.
    localparam int GAIN_PROD_W = 2 * LEVEL_W;
    localparam int GAIN_ROUND  = UNITY_GAIN / 2;
    localparam int GAIN_SHIFT  = $clog2(UNITY_GAIN);
    localparam logic [DIV_N_W-1:0] GAIN_SAT = DIV_N_W'(UNITY_GAIN) << LEVEL_W;

    localparam int ALPHA_SHIFT = 8;
    localparam int ALPHA_ONE   = 2 ** ALPHA_SHIFT;
    localparam int ALPHA_W     = ALPHA_SHIFT + 1;
    localparam int ALPHA_ROUND = ALPHA_ONE / 2;
    localparam int STEP_PROD_W = LEVEL_W + ALPHA_W;

    localparam logic [CFG_IDX_W-1:0] REG_VISUAL_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TIME = 2'd2;

    localparam logic [CFG_W-1:0] GAIN_RESET    = 16'd256;
    localparam logic [CFG_W-1:0] ATTACK_RESET  = 16'd0;
    localparam logic [CFG_W-1:0] RELEASE_RESET = 16'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_MS_MUL,
        S_MS_SET,
        S_TARGET,
        S_ALPHA_WAIT,
        S_STEP_MUL,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic ms_mul;
        logic ms_set;
        logic gain_set;
        logic target;
        logic alpha_start;
        logic step_mul;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic need_alpha;
        logic out_full;
    } dp_status_t;

endpackage

/* rtl/core/arls_if.sv */
// Item channels of the level smoother: raw samples in, smoothed levels out.
// Depends on arls_pkg for field widths.
interface arls_sample_if;
    logic                               valid;
    logic                               ready;
    logic                               frame_start;
    logic [arls_pkg::TIME_W-1:0]        time_us;
    logic [arls_pkg::CHANNEL_W-1:0]     channel;
    logic [arls_pkg::LEVEL_W-1:0]       target_level;

    modport source (output valid, frame_start, time_us, channel, target_level, input ready);
    modport sink   (input valid, frame_start, time_us, channel, target_level, output ready);
endinterface

interface arls_result_if;
    logic                               valid;
    logic                               ready;
    logic [arls_pkg::LEVEL_W-1:0]       smoothed_level;

    modport source (output valid, smoothed_level, input ready);
    modport sink   (input valid, smoothed_level, output ready);
endinterface

/* rtl/core/attack_release_level_smoother.sv */
// Top level of the attack/release level smoother: sequencer plus datapath.
// Depends on arls_pkg, arls_if, arls_ctrl, arls_dpath.
//
//   port       dir   handshake        carries
//   samples    sink  valid/ready      frame_start, time_us, channel, target_level
//   results    src   valid/ready      smoothed_level
//   cfg_*      in    cfg_we only      register index and 16-bit value
//
// One item at a time: after the accepting edge the sequencer steps through PREP,
// MS_MUL, MS_SET and TARGET; when the level moves it also divides for the Q8 fraction
// (ALPHA_WAIT, STEP_MUL); FINISH registers the result and the next item is taken in IDLE.
// Reset clears the level store valid bits, timer and configuration registers at once.
// A waiting result is held in the output register; the next item is accepted
// meanwhile and stalls only at its final write.
module attack_release_level_smoother (
    input  logic                                clk,
    input  logic                                rst_n,
    arls_sample_if.sink                         samples,
    arls_result_if.source                       results,
    input  logic                                cfg_we,
    input  logic [arls_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [arls_pkg::CFG_W-1:0]          cfg_wdata
);

    arls_pkg::dp_cmd_t      cmd;
    arls_pkg::dp_status_t   status;

    arls_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .cmd      (cmd),
        .status   (status)
    );

    arls_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .frame_start    (samples.frame_start),
        .time_us        (samples.time_us),
        .channel        (samples.channel),
        .target_level   (samples.target_level),
        .out_valid      (results.valid),
        .out_ready      (results.ready),
        .smoothed_level (results.smoothed_level)
    );

endmodule

/* rtl/core/arls_div.sv */
// Restoring divider, one quotient bit per cycle.
// Expects numer < denom * 2**DIV_Q_W. Depends on arls_pkg.
module arls_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [arls_pkg::DIV_N_W-1:0]   numer,
    input  logic [arls_pkg::DIV_D_W-1:0]   denom,
    output logic                           busy,
    output logic [arls_pkg::DIV_Q_W-1:0]   quot
);

    localparam int CNT_W = $clog2(arls_pkg::DIV_Q_W + 1);

    logic                           busy_reg;
    logic                           busy_next;
    logic [CNT_W-1:0]               cnt_reg;
    logic [CNT_W-1:0]               cnt_next;
    logic [arls_pkg::DIV_D_W-1:0]   rem_reg;
    logic [arls_pkg::DIV_Q_W-1:0]   quot_reg;
    logic [arls_pkg::DIV_D_W-1:0]   denom_reg;
    logic [arls_pkg::DIV_D_W:0]     trial;
    logic [arls_pkg::DIV_D_W:0]     trial_sub;
    logic                           fits;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[arls_pkg::DIV_Q_W-1]};
        trial_sub = trial - {1'b0, denom_reg};
        fits      = trial >= {1'b0, denom_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(arls_pkg::DIV_Q_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= numer[arls_pkg::DIV_N_W-1:arls_pkg::DIV_Q_W];
            quot_reg  <= numer[arls_pkg::DIV_Q_W-1:0];
            denom_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? trial_sub[arls_pkg::DIV_D_W-1:0] : trial[arls_pkg::DIV_D_W-1:0];
            quot_reg <= {quot_reg[arls_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

/* rtl/core/arls_ctrl.sv */
// Sequencer of the level smoother: steps the datapath through one item.
// Depends on arls_pkg for states, commands and status.
module arls_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output arls_pkg::dp_cmd_t       cmd,
    input  arls_pkg::dp_status_t    status
);

    arls_pkg::ctrl_state_t state_reg;
    arls_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arls_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            arls_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = arls_pkg::S_PREP;
                end
            end
            arls_pkg::S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = arls_pkg::S_MS_MUL;
            end
            arls_pkg::S_MS_MUL:
            begin
                cmd.ms_mul   = 1'b1;
                cmd.gain_set = 1'b1;
                state_next   = arls_pkg::S_MS_SET;
            end
            arls_pkg::S_MS_SET:
            begin
                cmd.ms_set = 1'b1;
                state_next = arls_pkg::S_TARGET;
            end
            arls_pkg::S_TARGET:
            begin
                cmd.target = 1'b1;
                if (status.need_alpha)
                begin
                    cmd.alpha_start = 1'b1;
                    state_next      = arls_pkg::S_ALPHA_WAIT;
                end
                else
                begin
                    state_next = arls_pkg::S_FINISH;
                end
            end
            arls_pkg::S_ALPHA_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = arls_pkg::S_STEP_MUL;
                end
            end
            arls_pkg::S_STEP_MUL:
            begin
                cmd.step_mul = 1'b1;
                state_next   = arls_pkg::S_FINISH;
            end
            arls_pkg::S_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = arls_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = arls_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/arls_dpath.sv */
// Datapath of the level smoother: config registers, frame timer, level store,
// gain and step arithmetic, output register. Depends on arls_pkg and arls_div.
module arls_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  arls_pkg::dp_cmd_t                  cmd,
    output arls_pkg::dp_status_t               status,
    input  logic                               cfg_we,
    input  logic [arls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [arls_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                               frame_start,
    input  logic [arls_pkg::TIME_W-1:0]        time_us,
    input  logic [arls_pkg::CHANNEL_W-1:0]     channel,
    input  logic [arls_pkg::LEVEL_W-1:0]       target_level,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [arls_pkg::LEVEL_W-1:0]       smoothed_level
);

    // configuration
    logic [arls_pkg::CFG_W-1:0]         gain_reg;
    logic [arls_pkg::CFG_W-1:0]         attack_reg;
    logic [arls_pkg::CFG_W-1:0]         release_reg;

    // latched item
    logic                               fs_reg;
    logic [arls_pkg::TIME_W-1:0]        time_reg;
    logic [arls_pkg::CHANNEL_W-1:0]     chan_reg;
    logic [arls_pkg::LEVEL_W-1:0]       raw_reg;

    // level store
    logic [arls_pkg::LEVEL_W-1:0]       level_mem [arls_pkg::LEVEL_DEPTH];
    logic [arls_pkg::LEVEL_DEPTH-1:0]   level_valid_reg;
    logic [arls_pkg::LEVEL_W-1:0]       rd_data_reg;
    logic                               rd_valid_reg;
    logic [arls_pkg::LEVEL_W-1:0]       stored_reg;

    // frame timer
    logic                               started_reg;
    logic [arls_pkg::TIME_W-1:0]        prev_reg;
    logic [arls_pkg::ELAPSED_W-1:0]     elapsed_reg;
    logic [arls_pkg::DELTA_W-1:0]       delta_reg;
    logic                               ms_pend_reg;
    logic [arls_pkg::MS_PROD_W-1:0]     ms_prod_reg;

    // arithmetic
    logic [arls_pkg::GAIN_PROD_W-1:0]   gain_prod_reg;
    logic                               gain_sat_reg;
    logic [arls_pkg::LEVEL_W-1:0]       gain_q_reg;
    logic                               up_reg;
    logic [arls_pkg::LEVEL_W-1:0]       diff_reg;
    logic                               direct_reg;
    logic [arls_pkg::LEVEL_W-1:0]       direct_val_reg;
    logic [arls_pkg::STEP_PROD_W-1:0]   step_prod_reg;

    // output
    logic                               out_valid_reg;
    logic [arls_pkg::LEVEL_W-1:0]       out_data_reg;

    logic [arls_pkg::TIME_W:0]          time_sub;
    logic                               no_advance;
    logic                               delta_capped;
    logic [arls_pkg::DIV_N_W-1:0]       gain_sum;
    logic                               gain_sat;
    logic [arls_pkg::LEVEL_W-1:0]       target_c;
    logic                               up_c;
    logic [arls_pkg::CFG_W-1:0]         resp_c;
    logic                               resp_zero;
    logic                               hold_c;
    logic                               need_alpha;
    logic [arls_pkg::LEVEL_W-1:0]       diff_c;
    logic [arls_pkg::DIV_N_W-1:0]       alpha_numer;
    logic [arls_pkg::DIV_D_W-1:0]       alpha_denom;
    logic                               div_start;
    logic [arls_pkg::DIV_N_W-1:0]       div_numer;
    logic [arls_pkg::DIV_D_W-1:0]       div_denom;
    logic                               div_busy;
    logic [arls_pkg::DIV_Q_W-1:0]       div_quot;
    logic [arls_pkg::ALPHA_W-1:0]       alpha_c;
    logic [arls_pkg::STEP_PROD_W:0]     step_round;
    logic [arls_pkg::LEVEL_W-1:0]       step_c;
    logic [arls_pkg::LEVEL_W-1:0]       step_min;
    logic [arls_pkg::LEVEL_W:0]         up_sum;
    logic [arls_pkg::LEVEL_W-1:0]       moved_c;
    logic [arls_pkg::LEVEL_W-1:0]       new_level;
    logic                               in_range;
    logic [arls_pkg::LEVEL_IDX_W-1:0]   wr_idx;
    logic [arls_pkg::LEVEL_IDX_W-1:0]   rd_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= arls_pkg::GAIN_RESET;
            attack_reg  <= arls_pkg::ATTACK_RESET;
            release_reg <= arls_pkg::RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                arls_pkg::REG_VISUAL_GAIN:  gain_reg    <= cfg_wdata;
                arls_pkg::REG_ATTACK_TIME:  attack_reg  <= cfg_wdata;
                arls_pkg::REG_RELEASE_TIME: release_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    assign rd_idx   = channel[arls_pkg::LEVEL_IDX_W-1:0];
    assign wr_idx   = chan_reg[arls_pkg::LEVEL_IDX_W-1:0];
    assign in_range = int'(chan_reg) < arls_pkg::NUM_CHANNELS;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            fs_reg      <= frame_start;
            time_reg    <= time_us;
            chan_reg    <= channel;
            raw_reg     <= target_level;
            rd_data_reg <= level_mem[rd_idx];
        end
        if (cmd.finish && in_range)
        begin
            level_mem[wr_idx] <= new_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_valid_reg <= level_valid_reg[rd_idx];
            end
            if (cmd.finish && in_range)
            begin
                level_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // frame timer
    always_comb
    begin
        time_sub     = {1'b0, time_reg} - {1'b0, prev_reg};
        no_advance   = time_sub[arls_pkg::TIME_W] || (time_sub[arls_pkg::TIME_W-1:0] == '0);
        delta_capped = time_sub[arls_pkg::TIME_W-1:0] >= arls_pkg::TIME_W'(arls_pkg::DELTA_CAP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            prev_reg    <= '0;
            elapsed_reg <= '0;
            ms_pend_reg <= 1'b0;
        end
        else if (cmd.prep)
        begin
            ms_pend_reg <= 1'b0;
            if (fs_reg)
            begin
                if (!started_reg)
                begin
                    started_reg <= 1'b1;
                    prev_reg    <= time_reg;
                    elapsed_reg <= arls_pkg::FIRST_ELAPSED_MS;
                end
                else if (no_advance)
                begin
                    elapsed_reg <= '0;
                end
                else
                begin
                    prev_reg <= time_reg;
                    if (delta_capped)
                    begin
                        elapsed_reg <= arls_pkg::MAX_ELAPSED_MS;
                    end
                    else
                    begin
                        ms_pend_reg <= 1'b1;
                    end
                end
            end
        end
        else if (cmd.ms_set && ms_pend_reg)
        begin
            elapsed_reg <= ms_prod_reg[arls_pkg::MS_RECIP_SHIFT +: arls_pkg::ELAPSED_W];
        end
    end

    // gain: round(raw * gain / UNITY_GAIN), saturating
    always_comb
    begin
        gain_sum = arls_pkg::DIV_N_W'(gain_prod_reg) + arls_pkg::DIV_N_W'(arls_pkg::GAIN_ROUND);
        gain_sat = gain_sum >= arls_pkg::GAIN_SAT;
    end

    // target and direction
    always_comb
    begin
        target_c    = gain_sat_reg ? arls_pkg::LEVEL_MAX : gain_q_reg;
        up_c        = target_c > stored_reg;
        resp_c      = up_c ? attack_reg : release_reg;
        resp_zero   = resp_c == '0;
        hold_c      = (target_c == stored_reg) || (elapsed_reg == '0);
        need_alpha  = !resp_zero && !hold_c;
        diff_c      = up_c ? (target_c - stored_reg) : (stored_reg - target_c);
        alpha_numer = arls_pkg::DIV_N_W'(elapsed_reg) << arls_pkg::ALPHA_SHIFT;
        alpha_denom = arls_pkg::DIV_D_W'(resp_c) + arls_pkg::DIV_D_W'(elapsed_reg);
    end

    always_comb
    begin
        div_start = cmd.alpha_start;
        div_numer = alpha_numer;
        div_denom = alpha_denom;
    end

    arls_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // step toward target
    always_comb
    begin
        alpha_c = (div_quot > arls_pkg::DIV_Q_W'(arls_pkg::ALPHA_ONE))
                  ? arls_pkg::ALPHA_W'(arls_pkg::ALPHA_ONE)
                  : div_quot[arls_pkg::ALPHA_W-1:0];
        step_round = {1'b0, step_prod_reg} + (arls_pkg::STEP_PROD_W + 1)'(arls_pkg::ALPHA_ROUND);
        step_c     = step_round[arls_pkg::ALPHA_SHIFT +: arls_pkg::LEVEL_W];
        step_min   = (step_c == '0) ? arls_pkg::LEVEL_W'(1) : step_c;
        up_sum     = {1'b0, stored_reg} + {1'b0, step_min};
        if (up_reg)
        begin
            moved_c = up_sum[arls_pkg::LEVEL_W] ? arls_pkg::LEVEL_MAX
                                                : up_sum[arls_pkg::LEVEL_W-1:0];
        end
        else
        begin
            moved_c = (step_min > stored_reg) ? '0 : (stored_reg - step_min);
        end
        new_level = direct_reg ? direct_val_reg : moved_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            stored_reg    <= rd_valid_reg ? rd_data_reg : '0;
            gain_prod_reg <= arls_pkg::GAIN_PROD_W'(raw_reg) * arls_pkg::GAIN_PROD_W'(gain_reg);
            delta_reg     <= time_sub[arls_pkg::DELTA_W-1:0];
        end
        if (cmd.ms_mul)
        begin
            ms_prod_reg <= arls_pkg::MS_PROD_W'(delta_reg)
                           * arls_pkg::MS_PROD_W'(arls_pkg::MS_RECIP);
        end
        if (cmd.gain_set)
        begin
            gain_sat_reg <= gain_sat;
            gain_q_reg   <= gain_sum[arls_pkg::GAIN_SHIFT +: arls_pkg::LEVEL_W];
        end
        if (cmd.target)
        begin
            up_reg         <= up_c;
            diff_reg       <= diff_c;
            direct_reg     <= !need_alpha;
            direct_val_reg <= resp_zero ? target_c : stored_reg;
        end
        if (cmd.step_mul)
        begin
            step_prod_reg <= arls_pkg::STEP_PROD_W'(diff_reg) * arls_pkg::STEP_PROD_W'(alpha_c);
        end
        if (cmd.finish)
        begin
            out_data_reg <= in_range ? new_level : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.div_busy   = div_busy;
    assign status.need_alpha = need_alpha;
    assign status.out_full   = out_valid_reg && !out_ready;

    assign out_valid      = out_valid_reg;
    assign smoothed_level = out_data_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alpha_start |-> !div_busy)
        else $error("divider started while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before delivery");

    a_elapsed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ms_set && ms_pend_reg) |=> (elapsed_reg <= arls_pkg::MAX_ELAPSED_MS))
        else $error("elapsed time above cap");

    a_elapsed_unstarted: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> (elapsed_reg == '0))
        else $error("elapsed time set before first frame");

endmodule

/* tb/attack_release_level_smoother_checker.sv */
// Scoreboard for the level smoother: follows register writes, predicts each smoothed level
// from accepted items and compares it with the returned results.
// Depends on arls_pkg and the item channel interfaces in arls_if.
module attack_release_level_smoother_checker
    import arls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    arls_sample_if               samples,
    arls_result_if               results,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output int                   mismatch_count,
    output int                   pending_levels
);

    logic [LEVEL_W-1:0]   level_store [NUM_CHANNELS];
    logic                 clock_running;
    logic [TIME_W-1:0]    last_stamp;
    logic [ELAPSED_W-1:0] frame_ms;
    logic [CFG_W-1:0]     gain;
    logic [CFG_W-1:0]     rise_time;
    logic [CFG_W-1:0]     fall_time;
    logic [LEVEL_W-1:0]   expected_levels [$];
    int                   mismatches;

    function automatic logic [LEVEL_W-1:0] gained_target(input logic [LEVEL_W-1:0] raw);
        logic [63:0] q;
        q = (64'(raw) * 64'(gain) + 64'(GAIN_ROUND)) / 64'(UNITY_GAIN);
        return (q > 64'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(q);
    endfunction

    function automatic void advance_clock(input logic [TIME_W-1:0] stamp);
        logic [TIME_W-1:0] ms;
        if (!clock_running)
        begin
            clock_running = 1'b1;
            last_stamp    = stamp;
            frame_ms      = FIRST_ELAPSED_MS;
        end
        else if (stamp <= last_stamp)
        begin
            frame_ms = '0;
        end
        else
        begin
            ms         = (stamp - last_stamp) / 64'(US_PER_MS);
            last_stamp = stamp;
            frame_ms   = (ms > 64'(MAX_ELAPSED_MS)) ? MAX_ELAPSED_MS : ELAPSED_W'(ms);
        end
    endfunction

    function automatic logic [LEVEL_W-1:0] stepped_level(input logic [LEVEL_W-1:0] stored,
                                                         input logic [LEVEL_W-1:0] goal,
                                                         input logic [ELAPSED_W-1:0] ms);
        logic [CFG_W-1:0]   resp;
        int unsigned        alpha;
        int unsigned        diff;
        int unsigned        step;
        int unsigned        sum;
        logic [LEVEL_W-1:0] result;
        resp = (goal > stored) ? rise_time : fall_time;
        if (resp == '0)
            result = goal;
        else if (goal == stored || ms == '0)
            result = stored;
        else
        begin
            alpha = (32'(ms) * ALPHA_ONE) / (32'(resp) + 32'(ms));
            if (alpha > ALPHA_ONE)
                alpha = ALPHA_ONE;
            diff = (goal > stored) ? 32'(goal) - 32'(stored) : 32'(stored) - 32'(goal);
            step = (diff * alpha + ALPHA_ROUND) / ALPHA_ONE;
            if (step == 0)
                step = 1;
            if (goal > stored)
            begin
                sum    = 32'(stored) + step;
                result = (sum > 32'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(sum);
            end
            else
                result = (step > 32'(stored)) ? '0 : LEVEL_W'(32'(stored) - step);
        end
        return result;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : observe
        int                 idx;
        logic [LEVEL_W-1:0] goal;
        logic [LEVEL_W-1:0] want;
        if (!rst_n)
        begin
            for (idx = 0; idx < NUM_CHANNELS; idx++)
                level_store[idx] = '0;
            clock_running = 1'b0;
            last_stamp    = '0;
            frame_ms      = '0;
            gain          = GAIN_RESET;
            rise_time     = ATTACK_RESET;
            fall_time     = RELEASE_RESET;
            expected_levels.delete();
            mismatches     = 0;
            mismatch_count <= 0;
            pending_levels <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VISUAL_GAIN:  gain      = cfg_wdata;
                    REG_ATTACK_TIME:  rise_time = cfg_wdata;
                    REG_RELEASE_TIME: fall_time = cfg_wdata;
                    default: ;
                endcase
            end

            if (results.valid && results.ready)
            begin
                if (expected_levels.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d",
                             $time, results.smoothed_level);
                    mismatches++;
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (results.smoothed_level !== want)
                    begin
                        $display("%0t: smoothed_level mismatch, expected %0d, got %0d",
                                 $time, want, results.smoothed_level);
                        mismatches++;
                    end
                end
            end

            if (samples.valid && samples.ready)
            begin
                if (samples.frame_start)
                    advance_clock(samples.time_us);
                if (int'(samples.channel) >= NUM_CHANNELS)
                    expected_levels.push_back('0);
                else
                begin
                    goal = gained_target(samples.target_level);
                    level_store[samples.channel] =
                        stepped_level(level_store[samples.channel], goal, frame_ms);
                    expected_levels.push_back(level_store[samples.channel]);
                end
            end

            mismatch_count <= mismatches;
            pending_levels <= expected_levels.size();
        end
    end

endmodule

/* tb/attack_release_level_smoother_tb.sv */
// Top of the level smoother bench: clock, reset, register phases, bursty item stimulus
// and a stalling result receiver. Depends on arls_pkg, arls_if, the block and the checker.
module attack_release_level_smoother_tb;
    import arls_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 50;
    localparam int PHASE_ITEMS    = 320;
    localparam int RANDOM_PHASES  = 6;

    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} rx_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    int                   mismatch_count;
    int                   pending_levels;
    logic [TIME_W-1:0]    now_us;
    int                   burst_left;

    arls_sample_if samples_ch ();
    arls_result_if results_ch ();

    attack_release_level_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    attack_release_level_smoother_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples_ch),
        .results        (results_ch),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending_levels (pending_levels)
    );

    always #1 clk = ~clk;

    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : receiver
        int       seg;
        int       span;
        rx_mode_t mode;
        seg = 0;
        results_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            seg++;
            if (seg % 6 == 2)
            begin
                mode = RX_HOLD;
                span = $urandom_range(250, 400);
            end
            else
            begin
                mode = rx_mode_t'($urandom_range(0, 2));
                span = $urandom_range(20, 300);
            end
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RX_OPEN:   results_ch.ready <= 1'b1;
                    RX_COIN:   results_ch.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: results_ch.ready <= ($urandom_range(0, 9) != 0);
                    default:   results_ch.ready <= 1'b0;
                endcase
            end
        end
    end

    function automatic logic [LEVEL_W-1:0] pick_level();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        else if (r < 4)
            return LEVEL_MAX;
        else if (r == 4)
            return LEVEL_W'($urandom_range(0, 255));
        return LEVEL_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd256;
            3:       return 16'hFFFF;
            4:       return CFG_W'($urandom_range(200, 300));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_response();
        case ($urandom_range(0, 6))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3, 4:    return CFG_W'($urandom_range(1, 500));
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic offer(input logic fs, input logic [TIME_W-1:0] t,
                         input logic [CHANNEL_W-1:0] ch, input logic [LEVEL_W-1:0] lvl);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                samples_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        samples_ch.valid        <= 1'b1;
        samples_ch.frame_start  <= fs;
        samples_ch.time_us      <= t;
        samples_ch.channel      <= ch;
        samples_ch.target_level <= lvl;
        do @(posedge clk); while (!samples_ch.ready);
    endtask

    task automatic settle();
        samples_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_levels != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] a,
                                input logic [CFG_W-1:0] r);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_VISUAL_GAIN;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_index <= REG_ATTACK_TIME;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_index <= REG_RELEASE_TIME;
        cfg_wdata <= r;
        @(posedge clk);
        // unmapped index, must leave every register alone
        cfg_index <= REG_UNUSED;
        cfg_wdata <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic frame_at(input int unsigned delta_us, input logic [CHANNEL_W-1:0] ch,
                            input logic [LEVEL_W-1:0] lvl);
        now_us += delta_us;
        offer(1'b1, now_us, ch, lvl);
    endtask

    task automatic random_item();
        logic              fs;
        logic [TIME_W-1:0] t;
        int                r;
        fs = ($urandom_range(0, 3) == 0);
        t  = {$urandom, $urandom};
        if (fs)
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                now_us += $urandom_range(1, 40000);
            else if (r < 16)
                now_us += $urandom_range(0, 1100000);
            else if (r == 16)
                now_us += $urandom_range(1001000, 50000000);
            if (r < 17)
                t = now_us;
            else
                t = (now_us > 20000) ? now_us - $urandom_range(0, 20000) : '0;
        end
        offer(fs, t, CHANNEL_W'($urandom_range(0, NUM_CHANNELS - 1)), pick_level());
    endtask

    initial
    begin : stimulus
        int phase;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= REG_VISUAL_GAIN;
        cfg_wdata               <= '0;
        samples_ch.valid        <= 1'b0;
        samples_ch.frame_start  <= 1'b0;
        samples_ch.time_us      <= '0;
        samples_ch.channel      <= '0;
        samples_ch.target_level <= '0;
        burst_left = 0;
        now_us     = 64'd5000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: zero response times jump to the target
        offer(1'b0, '0, 5'd0, 16'hFFFF);
        offer(1'b1, now_us, 5'd31, 16'h1234);     // first frame
        offer(1'b0, '1, 5'd0, 16'h0000);          // timestamp ignored without frame start

        program_regs(16'hFFFF, 16'd100, 16'd200);
        frame_at(0, 5'd1, 16'h0001);              // time not advancing
        frame_at(999999, 5'd1, 16'h0001);
        offer(1'b0, '0, 5'd1, 16'hFFFF);          // gain saturates
        frame_at(1000999, 5'd2, 16'h8000);        // just below the cap
        frame_at(1001000, 5'd2, 16'h8000);        // at the cap
        frame_at(500, 5'd3, 16'd100);             // under one millisecond
        offer(1'b1, '0, 5'd3, 16'd100);           // time going backward
        frame_at(33000, 5'd1, 16'h0000);
        offer(1'b0, '0, 5'd4, 16'h0000);          // equal levels hold

        program_regs(16'h0000, 16'hFFFF, 16'hFFFF);
        frame_at(40000, 5'd1, 16'hFFFF);          // minimum step of one
        offer(1'b0, '0, 5'd1, 16'h7FFF);

        program_regs(16'h0001, 16'h0001, 16'h0000);
        frame_at(1000, 5'd5, 16'hFFFF);
        offer(1'b0, '0, 5'd5, 16'h0000);
        offer(1'b0, '0, 5'd6, 16'd128);           // gain rounding
        offer(1'b0, '0, 5'd6, 16'd127);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       program_regs(16'd256, 16'd100, 16'd400);
                1:       program_regs(16'hFFFF, 16'd0, 16'hFFFF);
                2:       program_regs(16'd1, 16'hFFFF, 16'd1);
                default: program_regs(pick_gain(), pick_response(), pick_response());
            endcase
            repeat (PHASE_ITEMS) random_item();
        end

        // timestamp at the very top of the range, then repeated
        offer(1'b1, '1, 5'd7, 16'hFFFF);
        offer(1'b1, '1, 5'd7, 16'h0000);
        offer(1'b0, '0, 5'd7, 16'h5555);

        settle();
        if (mismatch_count == 0 && pending_levels == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/arls_pkg.sv
rtl/core/arls_if.sv
rtl/core/arls_div.sv
rtl/core/arls_ctrl.sv
rtl/core/arls_dpath.sv
rtl/core/attack_release_level_smoother.sv
tb/attack_release_level_smoother_checker.sv
tb/attack_release_level_smoother_tb.sv
